FILE: hdl/assert_macros.svh
// Assertion macros for the RTL.
// Needs nothing else; included by text_console_frame_writer, which checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TCFW_ASSERT_SYNC(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tcfw check failed");
`define TCFW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("tcfw check failed");
`else
`define TCFW_ASSERT_SYNC(lbl, clk, rst_n, prop)
`define TCFW_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/tcfw_pkg.sv
// Shared constants, request codes, RAM request type and the 5x7 font.
// No dependencies; imported by tcfw_seq and text_console_frame_writer.
package tcfw_pkg;

    localparam int COLUMNS   = 128;
    localparam int PAGES     = 8;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int PG_W      = $clog2(PAGES);
    localparam int ADDR_W    = PG_W + COL_W;
    localparam int MEM_DEPTH = PAGES << COL_W;
    localparam int CELL_W    = 6;
    localparam int GLYPH_W   = 5;
    localparam int KIND_IN_W = 2;
    localparam int CHAR_IN_W = 8;
    localparam int PAGE_IN_W = 3;
    localparam int COL_IN_W  = 7;
    localparam int DATA_W    = 8;
    localparam int FONT_W    = GLYPH_W * DATA_W;

    localparam logic [KIND_IN_W-1:0] KIND_CHAR = 2'd0;
    localparam logic [KIND_IN_W-1:0] KIND_SET  = 2'd1;
    localparam logic [KIND_IN_W-1:0] KIND_READ = 2'd2;

    localparam logic [CHAR_IN_W-1:0] CH_BELL  = 8'h07;
    localparam logic [CHAR_IN_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_IN_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_IN_W-1:0] CH_FF    = 8'h0C;
    localparam logic [CHAR_IN_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_IN_W-1:0] CH_FIRST = 8'h20;
    localparam logic [CHAR_IN_W-1:0] CH_LAST  = 8'h7A;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_ram_req;

    // logical page -> physical page, the store scrolls by rotating r_top
    function automatic logic [PG_W-1:0] phys_page(input logic [PG_W-1:0] top,
                                                   input logic [PG_W-1:0] pg);
        logic [PG_W:0] s;
        s = {1'b0, top} + {1'b0, pg};
        if (s >= (PG_W+1)'(PAGES))
            s = s - (PG_W+1)'(PAGES);
        return s[PG_W-1:0];
    endfunction

    // first column in the top byte
    function automatic logic [FONT_W-1:0] font(input logic [CHAR_IN_W-1:0] code);
        logic [FONT_W-1:0] g;
        case (code)
            8'h20: g = 40'h0000000000; 8'h21: g = 40'h00005F0000;
            8'h22: g = 40'h0007000700; 8'h23: g = 40'h147F147F14;
            8'h24: g = 40'h242A7F2A12; 8'h25: g = 40'h2313086462;
            8'h26: g = 40'h3649552250; 8'h27: g = 40'h0005030000;
            8'h28: g = 40'h001C224100; 8'h29: g = 40'h0041221C00;
            8'h2A: g = 40'h082A1C2A08; 8'h2B: g = 40'h08083E0808;
            8'h2C: g = 40'h0050300000; 8'h2D: g = 40'h0808080808;
            8'h2E: g = 40'h0060600000; 8'h2F: g = 40'h2010080402;
            8'h30: g = 40'h3E5149453E; 8'h31: g = 40'h00427F4000;
            8'h32: g = 40'h4261514946; 8'h33: g = 40'h2141454B31;
            8'h34: g = 40'h1814127F10; 8'h35: g = 40'h2745454539;
            8'h36: g = 40'h3C4A494930; 8'h37: g = 40'h0171090503;
            8'h38: g = 40'h3649494936; 8'h39: g = 40'h064949291E;
            8'h3A: g = 40'h0036360000; 8'h3B: g = 40'h0056360000;
            8'h3C: g = 40'h0008142241; 8'h3D: g = 40'h1414141414;
            8'h3E: g = 40'h4122140800; 8'h3F: g = 40'h0201510906;
            8'h40: g = 40'h324979413E; 8'h41: g = 40'h7E1111117E;
            8'h42: g = 40'h7F49494936; 8'h43: g = 40'h3E41414122;
            8'h44: g = 40'h7F4141221C; 8'h45: g = 40'h7F49494941;
            8'h46: g = 40'h7F09090101; 8'h47: g = 40'h3E41415132;
            8'h48: g = 40'h7F0808087F; 8'h49: g = 40'h00417F4100;
            8'h4A: g = 40'h2040413F01; 8'h4B: g = 40'h7F08142241;
            8'h4C: g = 40'h7F40404040; 8'h4D: g = 40'h7F0204027F;
            8'h4E: g = 40'h7F0408107F; 8'h4F: g = 40'h3E4141413E;
            8'h50: g = 40'h7F09090906; 8'h51: g = 40'h3E4151215E;
            8'h52: g = 40'h7F09192946; 8'h53: g = 40'h4649494931;
            8'h54: g = 40'h01017F0101; 8'h55: g = 40'h3F4040403F;
            8'h56: g = 40'h1F2040201F; 8'h57: g = 40'h7F2018207F;
            8'h58: g = 40'h6314081463; 8'h59: g = 40'h0304780403;
            8'h5A: g = 40'h6151494543; 8'h5B: g = 40'h00007F4141;
            8'h5C: g = 40'h0204081020; 8'h5D: g = 40'h41417F0000;
            8'h5E: g = 40'h0402010204; 8'h5F: g = 40'h4040404040;
            8'h60: g = 40'h0001020400; 8'h61: g = 40'h2054545478;
            8'h62: g = 40'h7F48444438; 8'h63: g = 40'h3844444420;
            8'h64: g = 40'h384444487F; 8'h65: g = 40'h3854545418;
            8'h66: g = 40'h087E090102; 8'h67: g = 40'h081454543C;
            8'h68: g = 40'h7F08040478; 8'h69: g = 40'h00447D4000;
            8'h6A: g = 40'h2040443D00; 8'h6B: g = 40'h007F102844;
            8'h6C: g = 40'h00417F4000; 8'h6D: g = 40'h7C04180478;
            8'h6E: g = 40'h7C08040478; 8'h6F: g = 40'h3844444438;
            8'h70: g = 40'h7C14141408; 8'h71: g = 40'h081414187C;
            8'h72: g = 40'h7C08040408; 8'h73: g = 40'h4854545420;
            8'h74: g = 40'h043F444020; 8'h75: g = 40'h3C4040207C;
            8'h76: g = 40'h1C2040201C; 8'h77: g = 40'h3C4030403C;
            8'h78: g = 40'h4428102844; 8'h79: g = 40'h0C5050503C;
            8'h7A: g = 40'h4464544C44;
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

FILE: hdl/tcfw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module tcfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we)
            r_mem[i_waddr] <= i_wdata;
        if (i_re)
            r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tcfw_seq.sv
// Request sequencer: cursor, page rotation, the write sweeps into the store and the reads.
// Depends on tcfw_pkg; drives the frame RAM through a t_ram_req bundle.
module tcfw_seq
    import tcfw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KIND_IN_W-1:0] i_kind,
    input  logic [CHAR_IN_W-1:0] i_char_code,
    input  logic [PAGE_IN_W-1:0] i_page,
    input  logic [COL_IN_W-1:0]  i_column,
    input  logic                 i_out_free,
    output t_ram_req             o_ram,
    output logic                 o_load,
    output logic                 o_load_zero
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CLEAR  = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_DRAW   = 3'd3;
    localparam logic [2:0] S_RD     = 3'd4;

    logic [2:0]        r_state,    n_state;
    logic [ADDR_W-1:0] r_cnt,      n_cnt;
    logic [PG_W-1:0]   r_top,      n_top;
    logic [PG_W-1:0]   r_cur_page, n_cur_page;
    logic [COL_W-1:0]  r_cur_col,  n_cur_col;
    logic              r_pend,     n_pend;
    logic              r_rd_zero,  n_rd_zero;
    logic [FONT_W-1:0] r_glyph,    n_glyph;

    logic              accept;
    logic              bottom;
    logic [PG_W-1:0]   draw_phys;
    logic [PG_W-1:0]   top_inc;

    assign accept     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);
    assign bottom     = (r_cur_page == PG_W'(PAGES - 1));
    assign draw_phys  = phys_page(r_top, r_cur_page);
    assign top_inc    = phys_page(r_top, PG_W'(1));

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_top      = r_top;
        n_cur_page = r_cur_page;
        n_cur_col  = r_cur_col;
        n_pend     = r_pend;
        n_rd_zero  = r_rd_zero;
        n_glyph    = r_glyph;
        o_ram      = '0;
        o_load     = 1'b0;
        o_load_zero = r_rd_zero;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_kind)
                        KIND_CHAR: begin
                            if (i_char_code == CH_CR) begin
                                n_cur_col = '0;
                            end else if (i_char_code == CH_LF) begin
                                if (bottom) begin
                                    n_state = S_SCROLL;
                                    n_cnt   = '0;
                                    n_pend  = 1'b0;
                                end else begin
                                    n_cur_page = r_cur_page + PG_W'(1);
                                end
                            end else if (i_char_code == CH_BS) begin
                                if (r_cur_col != '0) begin
                                    n_cur_col = (r_cur_col > COL_W'(CELL_W))
                                              ? r_cur_col - COL_W'(CELL_W) : '0;
                                end else if (r_cur_page != '0) begin
                                    n_cur_col  = COL_W'(COLUMNS - 8);
                                    n_cur_page = r_cur_page - PG_W'(1);
                                end
                            end else if (i_char_code == CH_FF) begin
                                n_state    = S_CLEAR;
                                n_cnt      = '0;
                                n_top      = '0;
                                n_cur_col  = '0;
                                n_cur_page = '0;
                            end else if (i_char_code >= CH_FIRST &&
                                         i_char_code <= CH_LAST) begin
                                n_glyph = font(i_char_code);
                                n_cnt   = '0;
                                n_state = S_DRAW;
                                // wrap before drawing past the right edge
                                if (r_cur_col > COL_W'(COLUMNS - 1 - CELL_W)) begin
                                    n_cur_col = '0;
                                    if (bottom) begin
                                        n_state = S_SCROLL;
                                        n_pend  = 1'b1;
                                    end else begin
                                        n_cur_page = r_cur_page + PG_W'(1);
                                    end
                                end
                            end
                            // bell and other codes: no action
                        end
                        KIND_SET: begin
                            n_cur_page = (int'(i_page) > PAGES - 1)
                                       ? PG_W'(PAGES - 1) : PG_W'(i_page);
                            n_cur_col  = (int'(i_column) > COLUMNS - 1)
                                       ? COL_W'(COLUMNS - 1) : COL_W'(i_column);
                        end
                        KIND_READ: begin
                            o_ram.re    = 1'b1;
                            o_ram.raddr = {phys_page(r_top, PG_W'(i_page)),
                                           COL_W'(i_column)};
                            n_rd_zero   = (int'(i_page) >= PAGES) ||
                                          (int'(i_column) >= COLUMNS);
                            n_state     = S_RD;
                        end
                        default: ;
                    endcase
                end
            end
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_cnt;
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt == ADDR_W'(MEM_DEPTH - 1))
                    n_state = S_IDLE;
            end
            S_SCROLL: begin
                // old top page becomes the blank bottom page
                o_ram.we    = 1'b1;
                o_ram.waddr = {r_top, r_cnt[COL_W-1:0]};
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt[COL_W-1:0] == COL_W'(COLUMNS - 1)) begin
                    n_top   = top_inc;
                    n_cnt   = '0;
                    n_pend  = 1'b0;
                    n_state = r_pend ? S_DRAW : S_IDLE;
                end
            end
            S_DRAW: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = {draw_phys, r_cur_col + COL_W'(r_cnt[2:0])};
                o_ram.wdata = r_glyph[FONT_W-1 -: DATA_W];
                n_glyph     = r_glyph << DATA_W;
                n_cnt       = r_cnt + ADDR_W'(1);
                if (r_cnt[2:0] == 3'(CELL_W - 1)) begin
                    n_cur_col = r_cur_col + COL_W'(CELL_W);
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                if (i_out_free) begin
                    o_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_top      <= '0;
            r_cur_page <= '0;
            r_cur_col  <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_top      <= n_top;
            r_cur_page <= n_cur_page;
            r_cur_col  <= n_cur_col;
            r_pend     <= n_pend;
        end
        r_rd_zero <= n_rd_zero;
        r_glyph   <= n_glyph;
    end

endmodule

FILE: hdl/text_console_frame_writer.sv
// A glyph is the request plus 6 RAM writes, one per cell column; a wrap on the last page
// first blanks the old top page, as a line feed there does; a form feed clears the store.
// A read passes the RAM read register and is loaded into the output register once that is
// free; that register lets the next request in while the byte waits. One write port sets
// the glyph rate. Reset (synchronous, active low) starts a clearing pass; ready stays low.
// Depends on tcfw_pkg, tcfw_seq, tcfw_ram and assert_macros.svh.
`include "assert_macros.svh"
module text_console_frame_writer
    import tcfw_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [KIND_IN_W-1:0] i_kind,
    input  logic [CHAR_IN_W-1:0] i_char_code,
    input  logic [PAGE_IN_W-1:0] i_page,
    input  logic [COL_IN_W-1:0]  i_column,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [DATA_W-1:0]    o_read_data
);

    t_ram_req          ram_req;
    logic [DATA_W-1:0] ram_rdata;
    logic              out_free;
    logic              load;
    logic              load_zero;
    logic              rd_req;
    logic              r_out_valid;
    logic [DATA_W-1:0] r_out_data;

    assign out_free = !r_out_valid || i_out_ready;
    assign rd_req   = i_in_valid && o_in_ready && (i_kind == KIND_READ);

    tcfw_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_kind      (i_kind),
        .i_char_code (i_char_code),
        .i_page      (i_page),
        .i_column    (i_column),
        .i_out_free  (out_free),
        .o_ram       (ram_req),
        .o_load      (load),
        .o_load_zero (load_zero)
    );

    tcfw_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (load)
            r_out_data <= load_zero ? '0 : ram_rdata;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    `TCFW_ASSERT_SYNC(a_read_issues_ram, i_clk, i_rst_n, rd_req |-> ram_req.re)
    `TCFW_ASSERT_SYNC(a_write_only_busy, i_clk, i_rst_n, ram_req.we |-> !o_in_ready)
    `TCFW_ASSERT_SYNC(a_no_overwrite, i_clk, i_rst_n, load |-> out_free)
    `TCFW_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (!o_in_ready && !o_out_valid))

endmodule
